@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL of the split-step phase rotator.
// Needs no other file; synthesis builds see empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/ssp_pkg.sv @@
// Package of the split-step phase rotator: commands, widths, constants and
// the CORDIC angle table. Depends on nothing.
`timescale 1ns / 1ps
package ssp_pkg;

    typedef enum logic [1:0] {
        CMD_LINEAR    = 2'd0,
        CMD_NONLINEAR = 2'd1,
        CMD_NORMALIZE = 2'd2,
        CMD_PASS      = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [31:0]        turns;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_rot;

    localparam int LOG2_GRID_POINTS_DEF = 15;
    localparam int CORDIC_STAGES_DEF    = 16;
    localparam logic [31:0] STEP_RESET  = 32'd42949673;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam longint GAIN_Q30 = 652032874;
    localparam int XY_W = 35;
    localparam int Z_W  = 34;

    // Angle of atan(2^-i) in Q0.32 turns.
    localparam logic [31:0] ATAN_TURNS [0:30] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1
    };

endpackage

@@ hdl/ssp_if.sv @@
// Stream interfaces of the split-step phase rotator: input samples and
// output results, each with valid, ready and payload. No dependencies.
`timescale 1ns / 1ps
interface ssp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] sample_re;
    logic signed [31:0] sample_im;
    logic [31:0]        wave_number_sq;

    modport source (output valid, command, sample_re, sample_im, wave_number_sq,
                    input ready);
    modport sink (input valid, command, sample_re, sample_im, wave_number_sq,
                  output ready);
endinterface

interface ssp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;

    modport source (output valid, result_re, result_im, input ready);
    modport sink (input valid, result_re, result_im, output ready);
endinterface

@@ hdl/ssp_phase.sv @@
// Phase front end: forms the rotation angle in turns for linear and
// nonlinear beats over eight register stages. Uses ssp_pkg.
`timescale 1ns / 1ps
module ssp_phase import ssp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_step,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_re,
    input  logic signed [31:0] i_im,
    input  logic [31:0]        i_k2,
    output t_rot               o_rot
);

    t_cmd               r_cmd [0:6];
    logic signed [31:0] r_re  [0:6];
    logic signed [31:0] r_im  [0:6];
    logic [31:0]        r_tlin [2:6];
    logic               r_neg  [3:6];

    logic signed [63:0] n_a_rr, n_a_ii, r_a_rr, r_a_ii;
    logic [63:0]        n_a_p, r_a_p;
    logic [63:0]        w_b_sum;
    logic [31:0]        n_b_p2, r_b_p2, r_c_p2;
    logic [61:0]        n_b_plo, n_b_phi, r_b_plo, r_b_phi;
    logic [62:0]        w_c_l;
    logic [31:0]        n_c_tlin;
    logic [63:0]        n_c_sq, r_c_sq;
    logic [39:0]        w_d_sh;
    logic signed [40:0] w_d_diff;
    logic               n_d_neg;
    logic [39:0]        n_d_m, r_d_m;
    logic [63:0]        n_e_mlo, r_e_mlo;
    logic [39:0]        n_e_mhi, r_e_mhi;
    logic [55:0]        n_f_rad, r_f_rad;
    logic [61:0]        n_g_rlo, r_g_rlo;
    logic [53:0]        n_g_rhi, r_g_rhi;
    logic [54:0]        w_h_t;
    logic [31:0]        w_h_tnl;
    t_rot               n_h_rot, r_h_rot;

    assign n_a_rr = i_re * i_re;
    assign n_a_ii = i_im * i_im;
    assign n_a_p  = i_k2 * i_step;

    assign w_b_sum = $unsigned(r_a_rr) + $unsigned(r_a_ii);
    assign n_b_p2  = w_b_sum[63:32];
    assign n_b_plo = r_a_p[31:0] * INV_TWO_PI_Q32;
    assign n_b_phi = r_a_p[63:32] * INV_TWO_PI_Q32;

    assign w_c_l    = {1'b0, r_b_phi} + {33'b0, r_b_plo[61:32]};
    assign n_c_tlin = 32'd0 - w_c_l[58:27];
    assign n_c_sq   = r_b_p2 * r_b_p2;

    assign w_d_sh   = r_c_sq[63:24];
    assign w_d_diff = $signed({9'b0, r_c_p2}) - $signed({1'b0, w_d_sh});
    assign n_d_neg  = w_d_diff[40];
    assign n_d_m    = n_d_neg ? 40'(-w_d_diff) : w_d_diff[39:0];

    assign n_e_mlo = r_d_m[31:0] * i_step;
    assign n_e_mhi = r_d_m[39:32] * i_step;

    assign n_f_rad = {r_e_mhi, 16'b0} + {8'b0, r_e_mlo[63:16]};

    assign n_g_rlo = r_f_rad[31:0] * INV_TWO_PI_Q32;
    assign n_g_rhi = r_f_rad[55:32] * INV_TWO_PI_Q32;

    assign w_h_t   = {1'b0, r_g_rhi} + {25'b0, r_g_rlo[61:32]};
    assign w_h_tnl = r_neg[6] ? 32'd0 - w_h_t[39:8] : w_h_t[39:8];

    always_comb begin
        n_h_rot.re = r_re[6];
        n_h_rot.im = r_im[6];
        case (r_cmd[6])
            CMD_LINEAR:    n_h_rot.turns = r_tlin[6];
            CMD_NONLINEAR: n_h_rot.turns = w_h_tnl;
            default:       n_h_rot.turns = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd[0] <= i_cmd;
            r_re[0]  <= i_re;
            r_im[0]  <= i_im;
            for (int k = 1; k < 7; k++) begin
                r_cmd[k] <= r_cmd[k-1];
                r_re[k]  <= r_re[k-1];
                r_im[k]  <= r_im[k-1];
            end
            r_tlin[2] <= n_c_tlin;
            for (int k = 3; k < 7; k++) begin
                r_tlin[k] <= r_tlin[k-1];
            end
            r_neg[3] <= n_d_neg;
            for (int k = 4; k < 7; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            r_a_rr  <= n_a_rr;
            r_a_ii  <= n_a_ii;
            r_a_p   <= n_a_p;
            r_b_p2  <= n_b_p2;
            r_b_plo <= n_b_plo;
            r_b_phi <= n_b_phi;
            r_c_p2  <= r_b_p2;
            r_c_sq  <= n_c_sq;
            r_d_m   <= n_d_m;
            r_e_mlo <= n_e_mlo;
            r_e_mhi <= n_e_mhi;
            r_f_rad <= n_f_rad;
            r_g_rlo <= n_g_rlo;
            r_g_rhi <= n_g_rhi;
            r_h_rot <= n_h_rot;
        end
    end

    assign o_rot = r_h_rot;

endmodule

@@ hdl/ssp_cordic.sv @@
// Pipelined CORDIC rotator with quadrant pre-rotation, gain correction,
// rounding and saturation, one stage per iteration. Uses ssp_pkg.
`timescale 1ns / 1ps
module ssp_cordic import ssp_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_rot               i_rot,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y
);

    localparam int PW = XY_W + 33;
    localparam logic signed [32:0] GAIN =
        33'(GAIN_Q30 + ((2 * GAIN_Q30 / 3) >> (2 * STAGES)));
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'd536870912);
    localparam logic signed [XY_W+2:0] SAT_MAX = (XY_W + 3)'(64'd2147483647);
    localparam logic signed [XY_W+2:0] SAT_MIN = -SAT_MAX - 1;

    logic [31:0]              w_qsum;
    logic [1:0]               w_q;
    logic [31:0]              w_r;
    logic signed [XY_W-1:0]   w_x0, w_y0, n_px, n_py;
    logic signed [XY_W-1:0]   r_x [0:STAGES];
    logic signed [XY_W-1:0]   r_y [0:STAGES];
    logic signed [Z_W-1:0]    r_z [0:STAGES];
    logic signed [PW-1:0]     r_mx, r_my;
    logic signed [31:0]       r_ox, r_oy;

    function automatic logic signed [31:0] f_round_sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0]   s;
        logic signed [XY_W+2:0] h;
        s = v + ROUND_HALF;
        h = s[PW-1:30];
        if (h > SAT_MAX) begin
            return SAT_MAX[31:0];
        end else if (h < SAT_MIN) begin
            return SAT_MIN[31:0];
        end
        return h[31:0];
    endfunction

    assign w_qsum = i_rot.turns + 32'h2000_0000;
    assign w_q    = w_qsum[31:30];
    assign w_r    = i_rot.turns - {w_q, 30'b0};
    assign w_x0   = XY_W'(i_rot.re);
    assign w_y0   = XY_W'(i_rot.im);

    always_comb begin
        case (w_q)
            2'd1: begin
                n_px = -w_y0;
                n_py = w_x0;
            end
            2'd2: begin
                n_px = -w_x0;
                n_py = -w_y0;
            end
            2'd3: begin
                n_px = w_y0;
                n_py = -w_x0;
            end
            default: begin
                n_px = w_x0;
                n_py = w_y0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_px;
            r_y[0] <= n_py;
            r_z[0] <= Z_W'($signed(w_r));
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TURNS[g]);
        logic signed [XY_W-1:0] w_xs, w_ys;
        assign w_xs = r_x[g] >>> g;
        assign w_ys = r_y[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][Z_W-1]) begin
                    r_x[g+1] <= r_x[g] - w_ys;
                    r_y[g+1] <= r_y[g] + w_xs;
                    r_z[g+1] <= r_z[g] - ANG;
                end else begin
                    r_x[g+1] <= r_x[g] + w_ys;
                    r_y[g+1] <= r_y[g] - w_xs;
                    r_z[g+1] <= r_z[g] + ANG;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx <= r_x[STAGES] * GAIN;
            r_my <= r_y[STAGES] * GAIN;
            r_ox <= f_round_sat(r_mx);
            r_oy <= f_round_sat(r_my);
        end
    end

    assign o_x = r_ox;
    assign o_y = r_oy;

endmodule

@@ hdl/split_step_phase_rotator.sv @@
// Split-step phase rotator: per grid point operator of a split-step Fourier
// solver. Beats arrive on i_sample (valid/ready) and leave on o_result.
// Command linear rotates by -k2*step/2, nonlinear by (|psi|^2-|psi|^4)*step,
// normalize divides by 2^LOG2_GRID_POINTS with rounding, the spare code
// passes the sample through. The step register is written through
// i_cfg_we/i_cfg_wdata and should change only while the block is idle.
// Throughput is one beat per cycle while results are taken. The pipeline
// has CORDIC_STAGES + 12 register stages: eight form the phase, one does
// the pre-rotation, one per CORDIC iteration, then gain multiply, rounding
// and the output register; o_result.valid follows the valid bits in r_vld.
// Reset (synchronous, active low) empties the pipeline and loads the step
// register with its default. When the receiver stalls with a result
// waiting, the whole pipeline holds and i_sample.ready drops; no beat is
// lost or repeated. Uses ssp_pkg, ssp_if, ssp_phase and ssp_cordic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module split_step_phase_rotator import ssp_pkg::*; #(
    parameter int LOG2_GRID_POINTS = LOG2_GRID_POINTS_DEF,
    parameter int CORDIC_STAGES    = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    ssp_in_if.sink      i_sample,
    ssp_out_if.source   o_result
);

    localparam int DL = CORDIC_STAGES + 11;
    localparam longint NORM_HALF = longint'(1) << (LOG2_GRID_POINTS - 1);

    logic [31:0]        r_step;
    logic               w_en;
    t_cmd               w_cmd;
    logic signed [32:0] w_sum_re, w_sum_im;
    logic signed [31:0] w_byp_re, w_byp_im;
    logic               w_rot;
    logic [DL-1:0]      r_vld;
    logic               r_dl_rot [0:DL-1];
    logic signed [31:0] r_dl_re  [0:DL-1];
    logic signed [31:0] r_dl_im  [0:DL-1];
    t_rot               w_front;
    logic signed [31:0] w_cx, w_cy;
    logic               r_out_vld;
    logic signed [31:0] r_out_re, r_out_im;

    assign w_en  = !r_out_vld || o_result.ready;
    assign w_cmd = t_cmd'(i_sample.command);

    assign w_sum_re = $signed({i_sample.sample_re[31], i_sample.sample_re})
                      + $signed(33'(NORM_HALF));
    assign w_sum_im = $signed({i_sample.sample_im[31], i_sample.sample_im})
                      + $signed(33'(NORM_HALF));

    always_comb begin
        w_rot    = 1'b0;
        w_byp_re = i_sample.sample_re;
        w_byp_im = i_sample.sample_im;
        case (w_cmd)
            CMD_LINEAR, CMD_NONLINEAR: begin
                w_rot = 1'b1;
            end
            CMD_NORMALIZE: begin
                w_byp_re = 32'(w_sum_re >>> LOG2_GRID_POINTS);
                w_byp_im = 32'(w_sum_im >>> LOG2_GRID_POINTS);
            end
            default: begin
                w_rot = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    ssp_phase u_phase (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_step (r_step),
        .i_cmd  (w_cmd),
        .i_re   (i_sample.sample_re),
        .i_im   (i_sample.sample_im),
        .i_k2   (i_sample.wave_number_sq),
        .o_rot  (w_front)
    );

    ssp_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rot (w_front),
        .o_x   (w_cx),
        .o_y   (w_cy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[DL-2:0], i_sample.valid};
            r_out_vld <= r_vld[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_rot[0] <= w_rot;
            r_dl_re[0]  <= w_byp_re;
            r_dl_im[0]  <= w_byp_im;
            for (int k = 1; k < DL; k++) begin
                r_dl_rot[k] <= r_dl_rot[k-1];
                r_dl_re[k]  <= r_dl_re[k-1];
                r_dl_im[k]  <= r_dl_im[k-1];
            end
            r_out_re <= r_dl_rot[DL-1] ? w_cx : r_dl_re[DL-1];
            r_out_im <= r_dl_rot[DL-1] ? w_cy : r_dl_im[DL-1];
        end
    end

    assign i_sample.ready     = w_en;
    assign o_result.valid     = r_out_vld;
    assign o_result.result_re = r_out_re;
    assign o_result.result_im = r_out_im;

    `ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_sample.valid && w_en, r_vld[0])
    `ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_vld) && r_out_vld)
    `ASSERT_NXT(a_last_drains, i_clk, i_rst_n, w_en && r_vld[DL-1], r_out_vld)
    `ASSERT_NXT(a_step_holds, i_clk, i_rst_n, !i_cfg_we, $stable(r_step))

endmodule
